### sv/scti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_pkg: shared types and constants for the sine/cosine table block
// Holds the angle constants, the reciprocal used for the modulo reduction,
// the quarter-wave Q15 sine table and the front/back transaction types.
// ----------------------------------------------------------------------------
package scti_pkg;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Angle constants in millidegrees
	localparam logic [18:0] FULL_TURN    = 19'd360000;
	localparam logic [17:0] HALF_TURN    = 18'd180000;
	localparam logic [16:0] QUARTER_TURN = 17'd90000;

	// 2^31 mod 360000, removes the bias of the offset-binary angle
	localparam logic [18:0] BIAS_REM     = 19'd83648;
	localparam logic [18:0] BIAS_ADD     = 19'd276352;

	// 360000 = 64 * 5625; reduce the upper 26 bits modulo 5625
	localparam logic [12:0] ODD_MOD      = 13'd5625;
	// floor(2^38 / 5625), quotient estimate is exact or one low
	localparam logic [25:0] ODD_RECIP    = 26'd48867183;
	localparam int          RECIP_SHIFT  = 38;

	// Position scale to a Q8 index over 128 intervals
	localparam logic [14:0] POS_SCALE    = 15'd23860;
	localparam logic [14:0] MAG_MAX      = 15'd32767;

	// Quarter-wave sine, Q15, 129 entries
	localparam logic [14:0] QUARTER_SINE [0:128] = '{
		15'd0,     15'd402,   15'd804,   15'd1206,  15'd1608,  15'd2009,  15'd2410,  15'd2811,
		15'd3212,  15'd3612,  15'd4011,  15'd4410,  15'd4808,  15'd5205,  15'd5602,  15'd5998,
		15'd6393,  15'd6786,  15'd7179,  15'd7571,  15'd7962,  15'd8351,  15'd8739,  15'd9126,
		15'd9512,  15'd9896,  15'd10278, 15'd10659, 15'd11039, 15'd11417, 15'd11793, 15'd12167,
		15'd12539, 15'd12910, 15'd13279, 15'd13645, 15'd14010, 15'd14372, 15'd14732, 15'd15090,
		15'd15446, 15'd15800, 15'd16151, 15'd16499, 15'd16846, 15'd17189, 15'd17530, 15'd17869,
		15'd18204, 15'd18537, 15'd18868, 15'd19195, 15'd19519, 15'd19841, 15'd20159, 15'd20475,
		15'd20787, 15'd21096, 15'd21403, 15'd21705, 15'd22005, 15'd22301, 15'd22594, 15'd22884,
		15'd23170, 15'd23452, 15'd23731, 15'd24007, 15'd24279, 15'd24547, 15'd24811, 15'd25072,
		15'd25329, 15'd25582, 15'd25832, 15'd26077, 15'd26319, 15'd26556, 15'd26790, 15'd27019,
		15'd27245, 15'd27466, 15'd27683, 15'd27896, 15'd28105, 15'd28310, 15'd28510, 15'd28706,
		15'd28898, 15'd29085, 15'd29268, 15'd29447, 15'd29621, 15'd29791, 15'd29956, 15'd30117,
		15'd30273, 15'd30424, 15'd30571, 15'd30714, 15'd30852, 15'd30985, 15'd31113, 15'd31237,
		15'd31356, 15'd31470, 15'd31580, 15'd31685, 15'd31785, 15'd31880, 15'd31971, 15'd32057,
		15'd32137, 15'd32213, 15'd32285, 15'd32351, 15'd32412, 15'd32469, 15'd32521, 15'd32567,
		15'd32609, 15'd32646, 15'd32678, 15'd32705, 15'd32728, 15'd32745, 15'd32757, 15'd32765,
		15'd32767
	};

	// Classified transaction handed from front to back
	typedef struct packed {
		logic        cosine;   // 1 = cosine
		logic [25:0] turn_hi;  // offset-binary angle, bits 31:6
		logic [5:0]  turn_lo;  // offset-binary angle, bits 5:0
	} scti_item_t;

	// Queue status seen by front and back
	typedef struct packed {
		logic full;
		logic empty;
	} scti_qstat_t;

endpackage

### sv/scti_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_front: input acceptance and classification
// Takes angle transactions while the queue has room, picks the function
// and turns the signed angle into offset binary split for the reduction.
// ----------------------------------------------------------------------------
module scti_front import scti_pkg::*; (
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] angle
	input  logic [0:0]  s_axis_tuser,  // [0] command
	input  scti_qstat_t q_stat,
	output logic        push,
	output scti_item_t  item
);

	// Accept whenever the queue can take the transaction
	assign s_axis_tready = !q_stat.full;
	assign push          = s_axis_tvalid && !q_stat.full;

	// Flip the sign bit: angle + 2^31 as an unsigned word
	always_comb begin
		item.cosine  = s_axis_tuser[0];
		item.turn_hi = {~s_axis_tdata[31], s_axis_tdata[30:6]};
		item.turn_lo = s_axis_tdata[5:0];
	end

endmodule

### sv/scti_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_queue: short queue between front and back
// Register-based FIFO of classified transactions with full/empty status.
// ----------------------------------------------------------------------------
module scti_queue import scti_pkg::*; #(
	parameter int Depth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  scti_item_t  wr_item,
	input  logic        pop,
	output scti_item_t  rd_item,
	output scti_qstat_t q_stat
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	scti_item_t            mem_q [Depth];
	logic       [PtrW-1:0] wr_ptr_q;
	logic       [PtrW-1:0] rd_ptr_q;
	logic       [CntW-1:0] cnt_q;

	// Status from the fill count
	assign q_stat.full  = (cnt_q == CntW'(Depth));
	assign q_stat.empty = (cnt_q == '0);
	assign rd_item      = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the incoming transaction
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

### sv/scti_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scti_back: reduction, folding and table interpolation pipeline
// Nine stages with one shared advance: modulo 360000 by reciprocal,
// bias and cosine offset, quadrant fold, scaling, lookup, interpolation.
// ----------------------------------------------------------------------------
module scti_back import scti_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  scti_qstat_t q_stat,
	input  scti_item_t  item,
	output logic        pop,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // [15:0] value
);

	logic        adv;
	logic [8:1]  vld_q;

	logic        cos_s1, cos_s2, cos_s3;
	logic [25:0] hi_s1, hi_s2;
	logic [5:0]  lo_s1, lo_s2;
	logic [51:0] prod_s1;
	logic [25:0] qn_s2;
	logic [18:0] ang_s3;
	logic [18:0] ang_s4;
	logic [17:0] half_s5;
	logic        neg_s5, neg_s6, neg_s7, neg_s8;
	logic [16:0] quad_s6;
	logic [31:0] pos_s7;
	logic [14:0] base_s8;
	logic [16:0] step_s8;
	logic        sat_s8;
	logic [15:0] value_q;
	logic        out_vld_q;

	logic [25:0] rem_full;
	logic [13:0] rem;
	logic [12:0] rem_fix;
	logic [18:0] turn;
	logic [18:0] cos_sum;
	logic [7:0]  idx;
	logic [7:0]  frac;
	logic [7:0]  tab_lo;
	logic [7:0]  tab_hi;
	logic [14:0] tab_base;
	logic [8:0]  diff;
	logic [14:0] mag;

	// Whole pipe moves while the output register is free
	assign adv           = !out_vld_q || m_axis_tready;
	assign pop           = adv && !q_stat.empty;
	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = value_q;

	// Valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_q     <= {vld_q[7:1], pop};
			out_vld_q <= vld_q[8];
		end
	end

	// Combinational pieces of the stages
	always_comb begin
		// s3: remainder modulo 5625, rebuild modulo 360000, drop the 2^31 bias
		rem_full = hi_s2 - qn_s2;
		rem      = rem_full[13:0];
		rem_fix  = (rem >= {1'b0, ODD_MOD}) ? 13'(rem - {1'b0, ODD_MOD}) : rem[12:0];
		turn     = {rem_fix, lo_s2};
		// s4: cosine offset
		cos_sum  = ang_s3 + 19'(QUARTER_TURN);
		// s8: table position
		idx      = pos_s7[31:24];
		frac     = pos_s7[23:16];
		tab_lo   = {1'b0, idx[6:0]};
		tab_hi   = tab_lo + 8'd1;
		tab_base = QUARTER_SINE[tab_lo];
		diff     = 9'(QUARTER_SINE[tab_hi] - tab_base);
		// output: interpolate and saturate
		mag      = sat_s8 ? MAG_MAX : 15'(base_s8 + 15'(step_s8[16:8]));
	end

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1: quotient estimate product
			cos_s1  <= item.cosine;
			hi_s1   <= item.turn_hi;
			lo_s1   <= item.turn_lo;
			prod_s1 <= 52'(item.turn_hi) * 52'(ODD_RECIP);
			// s2: quotient times modulus
			cos_s2  <= cos_s1;
			hi_s2   <= hi_s1;
			lo_s2   <= lo_s1;
			qn_s2   <= 26'(prod_s1[51:RECIP_SHIFT]) * 26'(ODD_MOD);
			// s3: reduced angle in [0, 360000)
			cos_s3  <= cos_s2;
			ang_s3  <= (turn >= BIAS_REM) ? turn - BIAS_REM : turn + BIAS_ADD;
			// s4: add quarter turn for cosine and wrap
			if (cos_s3) begin
				ang_s4 <= (cos_sum >= FULL_TURN) ? cos_sum - FULL_TURN : cos_sum;
			end else begin
				ang_s4 <= ang_s3;
			end
			// s5: fold lower half-circle, note the sign
			if (ang_s4 >= 19'(HALF_TURN)) begin
				half_s5 <= 18'(ang_s4 - 19'(HALF_TURN));
				neg_s5  <= 1'b1;
			end else begin
				half_s5 <= ang_s4[17:0];
				neg_s5  <= 1'b0;
			end
			// s6: fold into the first quadrant
			neg_s6  <= neg_s5;
			quad_s6 <= (half_s5 > 18'(QUARTER_TURN)) ? 17'(HALF_TURN - half_s5)
			                                          : half_s5[16:0];
			// s7: scale to Q8 position
			neg_s7  <= neg_s6;
			pos_s7  <= 32'(quad_s6) * 32'(POS_SCALE);
			// s8: lookup and slope product
			neg_s8  <= neg_s7;
			sat_s8  <= idx[7];
			base_s8 <= tab_base;
			step_s8 <= 17'(diff) * 17'(frac);
			// output register: apply sign
			value_q <= neg_s8 ? 16'(16'd0 - {1'b0, mag}) : {1'b0, mag};
		end
	end

endmodule

### sv/sine_cosine_table_interp_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_cosine_table_interp_top: Q15 sine/cosine of a millidegree angle
// Quarter-wave table with linear interpolation, stream in and stream out.
// ----------------------------------------------------------------------------
// The block takes one angle transaction per clock while the queue has room
// (tuser selects sine or cosine) and returns one Q15 value per transaction, in
// order. Any 32-bit angle is valid. A transaction passes the input queue and then
// a nine-stage pipeline (the reciprocal modulo reduction and bias removal, then
// offset and folding, scaling, table lookup, and interpolation and sign). With an
// empty queue the transaction is still written into the queue and read out into
// the first stage, passes s1 to s8 and then loads the output register.
// Sustained throughput is one transaction per cycle while the output is not
// stalled, set by the single shared advance of the pipeline. The queue lets the
// input keep flowing for up to QueueDepth transactions while the output is
// stalled.
module sine_cosine_table_interp_top import scti_pkg::*; #(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] angle
	input  logic [0:0]  s_axis_tuser,   // [0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] value
);

	scti_qstat_t q_stat;
	scti_item_t  wr_item;
	scti_item_t  rd_item;
	logic        push;
	logic        pop;

	scti_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.q_stat        (q_stat),
		.push          (push),
		.item          (wr_item)
	);

	scti_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.pop     (pop),
		.rd_item (rd_item),
		.q_stat  (q_stat)
	);

	scti_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_stat        (q_stat),
		.item          (rd_item),
		.pop           (pop),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// Never write into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_stat.full |-> !push)
		else $error("push into full queue");

	// Never read from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) q_stat.empty |-> !pop)
		else $error("pop from empty queue");

	// Queue cannot be full and empty at once
	assert property (@(posedge clk) disable iff (!arst_n) !(q_stat.full && q_stat.empty))
		else $error("queue full and empty");

	// Result magnitude never exceeds 32767
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata != 16'h8000))
		else $error("result out of Q15 range");

endmodule
